// ===== rtl/atc_pkg.sv =====
// Shared constants, types and helpers of the ANSI text console.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package atc_pkg;

    // Screen geometry and escape parameter limits.
    localparam int COLS      = 80;
    localparam int ROWS      = 25;
    localparam int CELLS     = COLS * ROWS;
    localparam int MAX_SLOT  = 10;
    localparam int NUM_SLOTS = MAX_SLOT + 1;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int ADDR_W = 11;
    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int NUM_W  = 16;
    localparam int CELL_W = 14;

    // Byte classes found by the front end.
    typedef enum logic [2:0] {
        CLS_READ  = 3'd0,
        CLS_ESC   = 3'd1,
        CLS_LF    = 3'd2,
        CLS_CR    = 3'd3,
        CLS_BS    = 3'd4,
        CLS_DEL   = 3'd5,
        CLS_PRINT = 3'd6,
        CLS_CTRL  = 3'd7
    } cls_t;

    // One queued item.
    typedef struct packed {
        cls_t              cls;
        logic [7:0]        data;
        logic [ADDR_W-1:0] addr;
    } item_t;

    // Cursor after one step back.
    typedef struct packed {
        logic             ok;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } back_t;

    // One step back, wrapping to the end of the row above.
    function automatic back_t step_back(input logic [ROW_W-1:0] row,
                                        input logic [COL_W-1:0] col);
        back_t r;
        r.ok  = 1'b1;
        r.row = row;
        r.col = col;
        if (col != '0) begin
            r.col = col - 1'b1;
        end else if (row != '0) begin
            r.row = row - 1'b1;
            r.col = COL_W'(COLS - 1);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    // Linear cell address of a screen position.
    function automatic logic [ADDR_W-1:0] cell_at(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
        return ADDR_W'(32'(row) * COLS + 32'(col));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ansi_text_console_top.sv =====
// Top level of the ANSI text console: front end, item queue and back end.
// Depends on atc_pkg, atc_front and atc_back.
//
//  Channel | Dir | Beat fields
//  s_      | in  | tuser: action; tdata: byte_in [7:0], cell_address [18:8]
//  m_      | out | tdata: cell_char [7:0], cell_foreground [10:8],
//          |     |        cell_background [13:11], cursor_position [24:14]
//
// Reads go through the registered read port of the screen store; an m sequence
// applies its parameter slots one at a time. A scroll copies each cell one row up
// and blanks the last row; a clear blanks every cell. After reset a clearing pass
// runs before the first beat is carried out; while results stall, the two-entry
// input queue accepts beats until it is full.
`timescale 1ns / 1ps
`default_nettype none

module ansi_text_console_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // byte_in [7:0], cell_address [18:8]
    input  wire logic        s_tuser,   // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // cell_char, cell_foreground,
                                        // cell_background, cursor_position
);
    import atc_pkg::*;

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    // Front end and queue.
    atc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Execution and result register.
    atc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/atc_front.sv =====
// Front end: accepts input beats, classifies the byte and queues up to two items.
// Depends on atc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atc_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [23:0]   s_tdata,   // byte_in [7:0], cell_address [18:8]
    input  wire logic          s_tuser,   // action
    output logic               q_valid,
    output atc_pkg::item_t     q_item,
    input  wire logic          q_pop
);
    import atc_pkg::*;

    item_t      slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_reg, rd_reg;
    item_t      in_item;
    logic       push;

    // Classify the incoming byte.
    always_comb begin
        in_item.data = s_tdata[7:0];
        in_item.addr = s_tdata[18:8];
        if (s_tuser) begin
            in_item.cls = CLS_READ;
        end else begin
            case (s_tdata[7:0])
                8'h1B:   in_item.cls = CLS_ESC;
                8'h0A:   in_item.cls = CLS_LF;
                8'h0D:   in_item.cls = CLS_CR;
                8'h08:   in_item.cls = CLS_BS;
                8'h7F:   in_item.cls = CLS_DEL;
                default: in_item.cls = (s_tdata[7:0] >= 8'h20 && s_tdata[7:0] <= 8'h7E)
                                       ? CLS_PRINT : CLS_CTRL;
            endcase
        end
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    // Queue pointers and storage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_reg <= ~wr_reg;
            end
            if (q_pop) begin
                rd_reg <= ~rd_reg;
            end
        end
        if (push) begin
            slot_reg[wr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/atc_back.sv =====
// Back end: parser state, cursor, colors, screen store and the result register.
// Depends on atc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atc_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    input  wire atc_pkg::item_t q_item,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [31:0]        m_tdata    // cell_char, cell_foreground,
                                          // cell_background, cursor_position
);
    import atc_pkg::*;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESCAPE = 2'd1;
    localparam logic [1:0] MODE_PARAMS = 2'd2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_SAVE   = 8'h37;
    localparam logic [7:0] CH_LOAD   = 8'h38;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_J      = 8'h4A;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_READ   = 6'b000010,
        ST_SCR_RD = 6'b000100,
        ST_SCR_WR = 6'b001000,
        ST_FILL   = 6'b010000,
        ST_COLOR  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] last_reg, last_next;
    logic              emit_reg, emit_next;
    logic              del_reg, del_next;
    logic [ROW_W-1:0]  row_reg, row_next, srow_reg, srow_next;
    logic [COL_W-1:0]  col_reg, col_next, scol_reg, scol_next;
    logic [2:0]        fg_reg, fg_next, bg_reg, bg_next;
    logic [1:0]        mode_reg, mode_next;
    logic [NUM_W-1:0]  num_reg [NUM_SLOTS];
    logic [NUM_W-1:0]  num_next [NUM_SLOTS];
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              ovalid_reg, ovalid_next;
    logic [7:0]        ochar_reg, ochar_next;
    logic [2:0]        ofg_reg, ofg_next, obg_reg, obg_next;

    // Screen store.
    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_reg, wd;
    logic [ADDR_W-1:0] ra, wa;
    logic              we;

    logic              out_free;
    logic [CELL_W-1:0] blank;
    logic [SLOT_W-1:0] nsel;
    logic [NUM_W-1:0]  nval, n0, cnt;
    logic [19:0]       grown;
    logic [16:0]       csum;
    logic [7:0]        b;
    back_t             bk;

    assign out_free = !ovalid_reg || m_tready;
    assign blank    = {bg_reg, fg_reg, CH_SPACE};
    assign nsel     = state_reg == ST_COLOR ? idx_reg[SLOT_W-1:0] : slot_reg;
    assign nval     = num_reg[nsel];
    assign n0       = num_reg[0];
    assign cnt      = (n0 == '0) ? NUM_W'(1) : n0;
    assign b        = q_item.data;
    assign grown    = {1'b0, nval, 3'b0} + {3'b0, nval, 1'b0} + 20'(b - CH_ZERO);
    assign csum     = 17'(col_reg) + 17'(cnt);
    assign bk       = step_back(row_reg, col_reg);

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {7'b0, cell_at(row_reg, col_reg), obg_reg, ofg_reg, ochar_reg};

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        last_next   = last_reg;
        emit_next   = emit_reg;
        del_next    = del_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        srow_next   = srow_reg;
        scol_next   = scol_reg;
        fg_next     = fg_reg;
        bg_next     = bg_reg;
        mode_next   = mode_reg;
        num_next    = num_reg;
        slot_next   = slot_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ochar_next  = ochar_reg;
        ofg_next    = ofg_reg;
        obg_next    = obg_reg;
        q_pop       = 1'b0;
        we          = 1'b0;
        wa          = idx_reg;
        wd          = blank;
        ra          = q_item.addr;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop       = 1'b1;
                    ovalid_next = 1'b1;
                    ochar_next  = '0;
                    ofg_next    = '0;
                    obg_next    = '0;
                    if (q_item.cls == CLS_READ) begin
                        if (32'(q_item.addr) < CELLS) begin
                            ovalid_next = 1'b0;
                            state_next  = ST_READ;
                        end
                    end else if (mode_reg == MODE_ESCAPE) begin
                        mode_next = MODE_NORMAL;
                        if (b == CH_LBRACK) begin
                            for (int k = 0; k < NUM_SLOTS; k++) begin
                                num_next[k] = '0;
                            end
                            slot_next = '0;
                            mode_next = MODE_PARAMS;
                        end else if (b == CH_SAVE) begin
                            srow_next = row_reg;
                            scol_next = col_reg;
                        end else if (b == CH_LOAD) begin
                            row_next = srow_reg;
                            col_next = scol_reg;
                        end
                    end else if (mode_reg == MODE_PARAMS) begin
                        if (b >= CH_ZERO && b <= CH_NINE) begin
                            num_next[slot_reg] = (grown > 20'hFFFF) ? 16'hFFFF : grown[15:0];
                        end else if (b == CH_SEMI && 32'(slot_reg) < MAX_SLOT) begin
                            slot_next = slot_reg + 1'b1;
                        end else begin
                            mode_next = MODE_NORMAL;
                            if (b == CH_M) begin
                                ovalid_next = 1'b0;
                                idx_next    = '0;
                                state_next  = ST_COLOR;
                            end else if (b == CH_D) begin
                                col_next = (cnt >= NUM_W'(col_reg)) ? '0
                                           : col_reg - COL_W'(cnt);
                            end else if (b == CH_C) begin
                                col_next = (32'(csum) >= COLS) ? COL_W'(COLS - 1)
                                           : COL_W'(csum);
                            end else if (b == CH_H || b == CH_F) begin
                                row_next = (32'(n0) >= ROWS) ? ROW_W'(ROWS - 1)
                                           : ROW_W'(n0);
                                col_next = (32'(num_reg[1]) >= COLS) ? COL_W'(COLS - 1)
                                           : COL_W'(num_reg[1]);
                            end else if (b == CH_J && n0 == NUM_W'(2)) begin
                                row_next    = '0;
                                col_next    = '0;
                                ovalid_next = 1'b0;
                                idx_next    = '0;
                                last_next   = ADDR_W'(CELLS - 1);
                                state_next  = ST_FILL;
                            end
                        end
                    end else begin
                        case (q_item.cls)
                            CLS_ESC: mode_next = MODE_ESCAPE;
                            CLS_CR:  col_next = '0;
                            CLS_BS: begin
                                row_next = bk.row;
                                col_next = bk.col;
                            end
                            CLS_LF: begin
                                if (32'(row_reg) == ROWS - 1) begin
                                    ovalid_next = 1'b0;
                                    idx_next    = '0;
                                    state_next  = ST_SCR_RD;
                                end else begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                            CLS_PRINT, CLS_DEL: begin
                                // Delete writes a space one cell back and leaves the cursor on that cell.
                                if (q_item.cls == CLS_PRINT || bk.ok) begin
                                    we = 1'b1;
                                    if (q_item.cls == CLS_PRINT) begin
                                        wa = cell_at(row_reg, col_reg);
                                        wd = {bg_reg, fg_reg, b};
                                    end else begin
                                        wa = cell_at(bk.row, bk.col);
                                        row_next = bk.row;
                                        col_next = bk.col;
                                    end
                                    if (32'(col_next) == COLS - 1
                                            && 32'(row_next) == ROWS - 1) begin
                                        col_next    = '0;
                                        del_next    = (q_item.cls == CLS_DEL);
                                        ovalid_next = 1'b0;
                                        idx_next    = '0;
                                        state_next  = ST_SCR_RD;
                                    end else if (q_item.cls == CLS_PRINT) begin
                                        if (32'(col_reg) == COLS - 1) begin
                                            col_next = '0;
                                            row_next = row_reg + 1'b1;
                                        end else begin
                                            col_next = col_reg + 1'b1;
                                        end
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end

            ST_READ: begin
                ovalid_next = 1'b1;
                ochar_next  = rd_reg[7:0];
                ofg_next    = rd_reg[10:8];
                obg_next    = rd_reg[13:11];
                state_next  = ST_IDLE;
            end

            // Scroll: copy each cell one row up.
            ST_SCR_RD: begin
                ra         = idx_reg + ADDR_W'(COLS);
                state_next = ST_SCR_WR;
            end

            ST_SCR_WR: begin
                we = 1'b1;
                wd = rd_reg;
                if (32'(idx_reg) == CELLS - COLS - 1) begin
                    idx_next   = ADDR_W'(CELLS - COLS);
                    last_next  = ADDR_W'(CELLS - 1);
                    state_next = ST_FILL;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCR_RD;
                end
            end

            // Blank a range of cells in the current colors.
            ST_FILL: begin
                we       = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == last_reg) begin
                    state_next = ST_IDLE;
                    emit_next  = 1'b1;
                    del_next   = 1'b0;
                    if (emit_reg) begin
                        ovalid_next = 1'b1;
                        ochar_next  = '0;
                        ofg_next    = '0;
                        obg_next    = '0;
                    end
                    if (del_reg) begin
                        row_next = bk.row;
                        col_next = bk.col;
                    end
                end
            end

            // Apply one color parameter per cycle.
            ST_COLOR: begin
                if (nval >= 16'd30 && nval <= 16'd37) begin
                    fg_next = 3'(nval - 16'd30);
                end else if (nval >= 16'd40 && nval <= 16'd47) begin
                    bg_next = 3'(nval - 16'd40);
                end else if (nval == 16'd39) begin
                    fg_next = 3'd7;
                end else if (nval == 16'd49) begin
                    bg_next = 3'd0;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg[SLOT_W-1:0] == slot_reg) begin
                    ovalid_next = 1'b1;
                    ochar_next  = '0;
                    ofg_next    = '0;
                    obg_next    = '0;
                    state_next  = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers; reset starts a clearing pass over the store.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_FILL;
            idx_reg    <= '0;
            last_reg   <= ADDR_W'(CELLS - 1);
            emit_reg   <= 1'b0;
            del_reg    <= 1'b0;
            row_reg    <= '0;
            col_reg    <= '0;
            srow_reg   <= '0;
            scol_reg   <= '0;
            fg_reg     <= 3'd7;
            bg_reg     <= 3'd0;
            mode_reg   <= MODE_NORMAL;
            slot_reg   <= '0;
            ovalid_reg <= 1'b0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                num_reg[k] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            last_reg   <= last_next;
            emit_reg   <= emit_next;
            del_reg    <= del_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            srow_reg   <= srow_next;
            scol_reg   <= scol_next;
            fg_reg     <= fg_next;
            bg_reg     <= bg_next;
            mode_reg   <= mode_next;
            slot_reg   <= slot_next;
            ovalid_reg <= ovalid_next;
            num_reg    <= num_next;
        end
        ochar_reg <= ochar_next;
        ofg_reg   <= ofg_next;
        obg_reg   <= obg_next;
    end

    // Screen store port: one write, one registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_reg <= mem[ra];
    end

endmodule

`default_nettype wire

// ===== test/ansi_text_console_checker.sv =====
// Checker of the ANSI text console: watches both channels, keeps its own
// screen model and compares every result beat. Depends on atc_pkg.
`timescale 1ns / 1ps

module ansi_text_console_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    output int               errors,
    output int               pending
);
    import atc_pkg::*;

    typedef enum logic [1:0] {
        PM_NORMAL = 2'd0,
        PM_ESCAPE = 2'd1,
        PM_PARAMS = 2'd2
    } pmode_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic [2:0]  fg;
        logic [2:0]  bg;
        logic [10:0] cur;
    } cell_result_t;

    localparam int NUM_LIMIT = 65535;

    logic [13:0]  screen [CELLS];
    int           crow, ccol, srow, scol;
    logic [2:0]   fg_now, bg_now;
    pmode_t       pmode;
    int           nums [NUM_SLOTS];
    int           nslot;
    cell_result_t expected_cells [$];

    function automatic logic [13:0] blank_cell();
        return {bg_now, fg_now, 8'h20};
    endfunction

    function automatic void next_row();
        crow++;
        if (crow >= ROWS) begin
            for (int k = 0; k < CELLS - COLS; k++) screen[k] = screen[k + COLS];
            for (int k = CELLS - COLS; k < CELLS; k++) screen[k] = blank_cell();
            crow--;
        end
    endfunction

    function automatic void put_char(input logic [7:0] c);
        screen[crow * COLS + ccol] = {bg_now, fg_now, c};
        ccol++;
        if (ccol >= COLS) begin
            ccol = 0;
            next_row();
        end
    endfunction

    function automatic bit step_left();
        if (ccol > 0) begin
            ccol--;
            return 1;
        end
        if (crow > 0) begin
            crow--;
            ccol = COLS - 1;
            return 1;
        end
        return 0;
    endfunction

    function automatic void feed_byte(input logic [7:0] b);
        int n;
        case (pmode)
            PM_ESCAPE: begin
                pmode = PM_NORMAL;
                if (b == "[") begin
                    foreach (nums[k]) nums[k] = 0;
                    nslot = 0;
                    pmode = PM_PARAMS;
                end else if (b == "7") begin
                    srow = crow;
                    scol = ccol;
                end else if (b == "8") begin
                    crow = srow;
                    ccol = scol;
                end
            end
            PM_PARAMS: begin
                if (b >= "0" && b <= "9") begin
                    n = nums[nslot] * 10 + (b - "0");
                    nums[nslot] = n > NUM_LIMIT ? NUM_LIMIT : n;
                    return;
                end
                if (b == ";" && nslot < MAX_SLOT) begin
                    nslot++;
                    return;
                end
                n = nums[0] == 0 ? 1 : nums[0];
                if (b == "m") begin
                    for (int k = 0; k <= nslot; k++) begin
                        if (nums[k] >= 30 && nums[k] <= 37) fg_now = 3'(nums[k] - 30);
                        else if (nums[k] >= 40 && nums[k] <= 47) bg_now = 3'(nums[k] - 40);
                        else if (nums[k] == 39) fg_now = 3'd7;
                        else if (nums[k] == 49) bg_now = 3'd0;
                    end
                end else if (b == "D") begin
                    ccol = n >= ccol ? 0 : ccol - n;
                end else if (b == "C") begin
                    ccol = ccol + n >= COLS ? COLS - 1 : ccol + n;
                end else if (b == "H" || b == "f") begin
                    crow = nums[0] >= ROWS ? ROWS - 1 : nums[0];
                    ccol = nums[1] >= COLS ? COLS - 1 : nums[1];
                end else if (b == "J" && nums[0] == 2) begin
                    for (int k = 0; k < CELLS; k++) screen[k] = blank_cell();
                    crow = 0;
                    ccol = 0;
                end
                pmode = PM_NORMAL;
            end
            default: begin
                if (b == 8'h1b) pmode = PM_ESCAPE;
                else if (b == 8'h0a) next_row();
                else if (b == 8'h7f) begin
                    if (step_left()) begin
                        put_char(8'h20);
                        void'(step_left());
                    end
                end else if (b == 8'h0d) ccol = 0;
                else if (b == 8'h08) void'(step_left());
                else if (b >= 8'h20 && b <= 8'h7e) put_char(b);
            end
        endcase
    endfunction

    // Works out the result beat of one accepted input beat.
    function automatic cell_result_t predict_cell(input logic act, input logic [7:0] b,
                                                  input logic [10:0] addr);
        cell_result_t r;
        r = '0;
        if (!act) feed_byte(b);
        else if (addr < CELLS) {r.bg, r.fg, r.ch} = screen[addr];
        r.cur = 11'(crow * COLS + ccol);
        return r;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    assign pending = expected_cells.size();

    initial begin
        errors = 0;
        for (int k = 0; k < CELLS; k++) screen[k] = {3'd0, 3'd7, 8'h20};
        crow = 0; ccol = 0; srow = 0; scol = 0;
        fg_now = 3'd7; bg_now = 3'd0;
        pmode = PM_NORMAL; nslot = 0;
        foreach (nums[k]) nums[k] = 0;
    end

    // Input beats produce expectations; result beats are checked in order.
    always @(posedge aclk) begin
        cell_result_t want, got;
        if (aresetn && s_tvalid && s_tready)
            expected_cells.push_back(predict_cell(s_tuser, s_tdata[7:0], s_tdata[18:8]));
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[7:0], m_tdata[10:8], m_tdata[13:11], m_tdata[24:14]};
            if (expected_cells.size() == 0) begin
                report("unexpected beat", int'(m_tdata), 0);
            end else begin
                want = expected_cells.pop_front();
                if (got.ch != want.ch) report("cell_char", got.ch, want.ch);
                if (got.fg != want.fg) report("cell_foreground", got.fg, want.fg);
                if (got.bg != want.bg) report("cell_background", got.bg, want.bg);
                if (got.cur != want.cur) report("cursor_position", got.cur, want.cur);
            end
        end
    end

endmodule

// ===== test/ansi_text_console_top_test.sv =====
// Testbench top of the ANSI text console: drives byte and read beats with
// random gaps and gives the verdict. Depends on atc_pkg and the checker.
`timescale 1ns / 1ps

module ansi_text_console_top_test;
    import atc_pkg::*;

    localparam int CYCLE_LIMIT = 30000000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    int          errors, pending;
    int          cycles = 0;
    bit          calm = 0;

    always #5 aclk = ~aclk;

    ansi_text_console_top DUT (.*);

    ansi_text_console_checker checker_i (.*);

    // Run guard.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side stalls in bursts until the calm tail.
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 0;
                n = $urandom_range(1, 12);
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_tready <= 1;
            end
        end
    end

    // Sends one beat and holds it until accepted; returns at the accepting edge.
    task automatic send_beat(input logic act, input logic [7:0] b, input logic [10:0] addr);
        int n;
        @(negedge aclk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            n = $urandom_range(1, 12);
            repeat (n) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= act;
        s_tdata  <= {5'd0, addr, b};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drops valid after the last beat of a burst.
    task automatic stop_beats();
        @(negedge aclk);
        s_tvalid <= 0;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_beat(0, s[k], 11'($urandom));
    endtask

    task automatic read_cell(input int addr);
        send_beat(1, 8'($urandom), 11'(addr));
    endtask

    task automatic random_sequence();
        int pick;
        string s;
        pick = $urandom_range(0, 9);
        case (pick)
            0: s = $sformatf("\033[%0d;%0dH", $urandom_range(0, 30), $urandom_range(0, 90));
            1: s = $sformatf("\033[%0d;%0dm", $urandom_range(29, 50), $urandom_range(29, 50));
            2: s = $sformatf("\033[%0dD", $urandom_range(0, 20));
            3: s = $sformatf("\033[%0dC", $urandom_range(0, 20));
            4: s = $urandom_range(0, 1) ? "\0337" : "\0338";
            5: s = "\n\r";
            6: s = $urandom_range(0, 1) ? "\010" : "\177";
            default: s = "";
        endcase
        if (s.len() > 0) begin
            send_text(s);
        end else if (pick == 7) begin
            send_beat(0, 8'($urandom), 11'($urandom));
        end else begin
            send_beat(0, 8'($urandom_range(8'h20, 8'h7e)), 11'($urandom));
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1;

        // Directed part: printing, controls, escapes and the special cases.
        send_text("A~");
        read_cell(0);
        read_cell(1);
        read_cell(CELLS - 1);
        read_cell(2047);
        send_text("\033[99999;99999H");
        send_text("Z\177\010");
        send_text("\033[31;44m\033[;;;;;;;;;;;m");
        send_beat(0, 8'hff, 11'h7ff);
        send_beat(0, 8'h00, 11'h000);
        send_text("\033[2J");
        read_cell(0);
        stop_beats();

        // Hold off until the block has drained.
        wait (pending == 0);
        @(negedge aclk);

        for (int k = 0; k < 560; k++) begin
            if (k > 480) calm = 1;
            if ($urandom_range(0, 3) == 0) read_cell($urandom_range(0, 2047));
            else random_sequence();
            if (k % 250 == 249) send_text("\033[39;49m");
        end
        stop_beats();

        wait (pending == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
